/* design/tpgt_pkg.sv */
package tpgt_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [2:0] REG_GOAL_DISTANCE  = 3'd2;
	localparam logic [2:0] REG_GOAL_DIRECTION = 3'd3;
	localparam logic [2:0] REG_DURATION_TICKS = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [15:0] PROP_GAIN_RST = 16'd2560;
	localparam logic [15:0] DURATION_RST  = 16'd100;

	// Angle constants in 1/64 degree.
	localparam int HALF_TURN    = 11520;
	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;

	// Sequencing lengths.
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 39;

	// CORDIC start value, which folds in the inverse of the CORDIC gain.
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	typedef struct packed {
		logic signed [23:0] position_x;
		logic signed [23:0] position_y;
		logic signed [15:0] heading_now;
	} in_t;

	typedef struct packed {
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] turn_rate;
		logic               clear_odometry;
	} out_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CINIT,
		OP_CSTEP,
		OP_GMUL_X,
		OP_GMUL_Y,
		OP_GSTORE,
		OP_IMUL_X,
		OP_IMUL_Y,
		OP_DSTART,
		OP_DSTEP,
		OP_ERR,
		OP_PMUL,
		OP_ISUM,
		OP_ROUND,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] idx;
	} cmd_t;

	typedef struct packed {
		logic started;
	} stat_t;

	// Arctangent of 2^-i in 1/64 degree scaled by 256.
	function automatic logic signed [23:0] cordic_atan(input logic [3:0] i);
		logic signed [23:0] v;
		case (i)
			4'd0:    v = 24'sd737280;
			4'd1:    v = 24'sd435242;
			4'd2:    v = 24'sd229970;
			4'd3:    v = 24'sd116736;
			4'd4:    v = 24'sd58595;
			4'd5:    v = 24'sd29326;
			4'd6:    v = 24'sd14667;
			4'd7:    v = 24'sd7334;
			4'd8:    v = 24'sd3667;
			4'd9:    v = 24'sd1833;
			4'd10:   v = 24'sd917;
			4'd11:   v = 24'sd458;
			4'd12:   v = 24'sd229;
			4'd13:   v = 24'sd115;
			4'd14:   v = 24'sd57;
			default: v = 24'sd29;
		endcase
		return v;
	endfunction

endpackage

/* design/tpgt_ctrl.sv */
module tpgt_ctrl import tpgt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CINIT,
		S_CSTEP,
		S_GMUL_X,
		S_GMUL_Y,
		S_GSTORE,
		S_IMUL_X,
		S_IMUL_Y,
		S_DSTART,
		S_DSTEP,
		S_ERR,
		S_PMUL,
		S_ISUM,
		S_ROUND,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       out_free;

	// The output register may be loaded when it is empty or being drained.
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Command decode from the current state.
	always_comb begin
		cmd.idx = cnt_q[3:0];
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_CINIT:  cmd.op = OP_CINIT;
			S_CSTEP:  cmd.op = OP_CSTEP;
			S_GMUL_X: cmd.op = OP_GMUL_X;
			S_GMUL_Y: cmd.op = OP_GMUL_Y;
			S_GSTORE: cmd.op = OP_GSTORE;
			S_IMUL_X: cmd.op = OP_IMUL_X;
			S_IMUL_Y: cmd.op = OP_IMUL_Y;
			S_DSTART: cmd.op = OP_DSTART;
			S_DSTEP:  cmd.op = OP_DSTEP;
			S_ERR:    cmd.op = OP_ERR;
			S_PMUL:   cmd.op = OP_PMUL;
			S_ISUM:   cmd.op = OP_ISUM;
			S_ROUND:  cmd.op = OP_ROUND;
			S_OUT:    cmd.op = out_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Sequencer state, step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= stat.started ? S_IMUL_X : S_CINIT;
					end
				end
				S_CINIT: begin
					cnt_q   <= '0;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
						state_q <= S_GMUL_X;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_GMUL_X: state_q <= S_GMUL_Y;
				S_GMUL_Y: state_q <= S_GSTORE;
				S_GSTORE: state_q <= S_IMUL_X;
				S_IMUL_X: state_q <= S_IMUL_Y;
				S_IMUL_Y: state_q <= S_DSTART;
				S_DSTART: begin
					cnt_q   <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= S_ERR;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_ERR: begin
					cnt_q   <= '0;
					state_q <= S_PMUL;
				end
				S_PMUL: state_q <= S_ISUM;
				S_ISUM: state_q <= S_ROUND;
				S_ROUND: begin
					if (cnt_q == 6'd2) begin
						state_q <= S_OUT;
					end else begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= S_PMUL;
					end
				end
				S_OUT: begin
					// A result being drained in this cycle is replaced at once.
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else if (out_valid && out_ready) begin
						out_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/tpgt_dpath.sv */
module tpgt_dpath import tpgt_pkg::*; #(
	parameter int ACC_WIDTH = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  in_t         in_data,
	input  cmd_t        cmd,
	output stat_t       stat,
	output out_t        out_data
);

	localparam int EW = ACC_WIDTH + 27;
	localparam logic signed [EW-1:0] SUM_HI =
		EW'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
	localparam logic signed [EW-1:0] SUM_LO = -SUM_HI - EW'(1);
	localparam logic signed [EW-1:0] CAP_HI = EW'(43'sd2199023255551);
	localparam logic signed [EW-1:0] CAP_LO = EW'(-43'sd2199023255552);

	// Configuration registers.
	logic        [15:0] prop_gain_q;
	logic        [15:0] integ_gain_q;
	logic        [22:0] goal_dist_q;
	logic signed [14:0] goal_dir_q;
	logic        [15:0] duration_q;

	// Tracker state.
	logic                        started_q;
	logic signed [15:0]          start_heading_q;
	logic signed [23:0]          target_x_q;
	logic signed [23:0]          target_y_q;
	logic        [15:0]          elapsed_q;
	logic signed [ACC_WIDTH-1:0] sum_x_q;
	logic signed [ACC_WIDTH-1:0] sum_y_q;
	logic signed [ACC_WIDTH-1:0] sum_h_q;
	logic signed [15:0]          last_err_q;

	// Working registers.
	logic signed [23:0] px_q;
	logic signed [23:0] py_q;
	logic signed [15:0] hd_q;
	logic               first_q;
	logic signed [32:0] cx_q;
	logic signed [32:0] cy_q;
	logic signed [23:0] cz_q;
	logic               neg_q;
	logic signed [65:0] prod_q;
	logic signed [65:0] acc_q;
	logic        [38:0] dvd_x_q;
	logic        [38:0] dvd_y_q;
	logic        [15:0] rem_x_q;
	logic        [15:0] rem_y_q;
	logic signed [25:0] err_x_q;
	logic signed [25:0] err_y_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] vt_q;
	out_t               out_q;

	logic signed [15:0] dir_w;
	logic signed [15:0] dir_f;
	logic               dir_neg;
	logic signed [23:0] mul_a;
	logic signed [41:0] mul_b;
	logic signed [24:0] mag_x;
	logic signed [24:0] mag_y;
	logic signed [25:0] des_x;
	logic signed [25:0] des_y;
	logic signed [25:0] ex;
	logic signed [25:0] ey;
	logic signed [15:0] herr;
	logic signed [25:0] err_sel;
	logic signed [ACC_WIDTH-1:0] sum_sel;
	logic        [16:0] trial_x;
	logic        [16:0] trial_y;

	assign stat.started = started_q;
	assign out_data     = out_q;

	// Saturating add into an integral.
	function automatic logic [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] s,
		input logic signed [25:0]          e
	);
		logic signed [EW-1:0] t;
		t = EW'(s) + EW'(e);
		if (t > SUM_HI) begin
			t = SUM_HI;
		end else if (t < SUM_LO) begin
			t = SUM_LO;
		end
		return t[ACC_WIDTH-1:0];
	endfunction

	// Beyond this bound the integral term alone saturates the output.
	function automatic logic [41:0] sum_cap(input logic signed [ACC_WIDTH-1:0] s);
		logic signed [EW-1:0] t;
		t = EW'(s);
		if (t > CAP_HI) begin
			t = CAP_HI;
		end else if (t < CAP_LO) begin
			t = CAP_LO;
		end
		return t[41:0];
	endfunction

	// Round the CORDIC product to Q7.16, apply the fold sign and clamp.
	function automatic logic [23:0] goal_fix(
		input logic signed [65:0] p,
		input logic               neg
	);
		logic signed [65:0] t;
		logic signed [35:0] r;
		t = p + (66'sd1 <<< 29);
		r = t[65:30];
		if (neg) begin
			r = -r;
		end
		if (r > 36'sd8388607) begin
			r = 36'sd8388607;
		end else if (r < -36'sd8388608) begin
			r = -36'sd8388608;
		end
		return r[23:0];
	endfunction

	// Round from Q.8 half up and saturate to 32 bits.
	function automatic logic [31:0] drive_sat(input logic signed [66:0] s);
		logic signed [66:0] t;
		t = (s + 67'sd128) >>> 8;
		if (t > 67'sd2147483647) begin
			t = 67'sd2147483647;
		end else if (t < -67'sd2147483648) begin
			t = -67'sd2147483648;
		end
		return t[31:0];
	endfunction

	// Wrap a heading difference into the half-open range above minus a half turn.
	function automatic logic [15:0] wrap_heading(input logic signed [16:0] e);
		logic signed [16:0] r;
		r = e;
		for (int k = 0; k < 3; k++) begin
			if (r > 17'(HALF_TURN)) begin
				r = r - 17'(FULL_TURN);
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (r <= -17'(HALF_TURN)) begin
				r = r + 17'(FULL_TURN);
			end
		end
		return r[15:0];
	endfunction

	// Goal direction wrapped to a half turn, then folded into the CORDIC range.
	always_comb begin
		dir_w   = 16'(goal_dir_q);
		dir_neg = 1'b0;
		if (dir_w > 16'(HALF_TURN)) begin
			dir_w = dir_w - 16'(FULL_TURN);
		end else if (dir_w < -16'(HALF_TURN)) begin
			dir_w = dir_w + 16'(FULL_TURN);
		end
		dir_f = dir_w;
		if (dir_w > 16'(QUARTER_TURN)) begin
			dir_f   = dir_w - 16'(HALF_TURN);
			dir_neg = 1'b1;
		end else if (dir_w < -16'(QUARTER_TURN)) begin
			dir_f   = dir_w + 16'(HALF_TURN);
			dir_neg = 1'b1;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mag_x   = target_x_q[23] ? -25'(target_x_q) : 25'(target_x_q);
		mag_y   = target_y_q[23] ? -25'(target_y_q) : 25'(target_y_q);
		case (cmd.idx[1:0])
			2'd0:    err_sel = err_x_q;
			2'd1:    err_sel = err_y_q;
			default: err_sel = 26'(last_err_q);
		endcase
		case (cmd.idx[1:0])
			2'd0:    sum_sel = sum_x_q;
			2'd1:    sum_sel = sum_y_q;
			default: sum_sel = sum_h_q;
		endcase
		case (cmd.op)
			OP_GMUL_X: begin
				mul_a = 24'({1'b0, goal_dist_q});
				mul_b = 42'(cx_q);
			end
			OP_GMUL_Y: begin
				mul_a = 24'({1'b0, goal_dist_q});
				mul_b = 42'(cy_q);
			end
			OP_IMUL_X: begin
				mul_a = 24'({1'b0, elapsed_q});
				mul_b = 42'(mag_x);
			end
			OP_IMUL_Y: begin
				mul_a = 24'({1'b0, elapsed_q});
				mul_b = 42'(mag_y);
			end
			OP_PMUL: begin
				mul_a = 24'({1'b0, prop_gain_q});
				mul_b = 42'(err_sel);
			end
			default: begin
				mul_a = 24'({1'b0, integ_gain_q});
				mul_b = signed'(sum_cap(sum_sel));
			end
		endcase
	end

	// Desired point on the line, errors and the wrapped heading error.
	always_comb begin
		if (elapsed_q >= duration_q) begin
			des_x = 26'(target_x_q);
			des_y = 26'(target_y_q);
		end else begin
			des_x = target_x_q[23] ? -26'({2'b00, dvd_x_q[23:0]}) :
				26'({2'b00, dvd_x_q[23:0]});
			des_y = target_y_q[23] ? -26'({2'b00, dvd_y_q[23:0]}) :
				26'({2'b00, dvd_y_q[23:0]});
		end
		ex   = des_x - 26'(px_q);
		ey   = des_y - 26'(py_q);
		herr = signed'(wrap_heading(17'(start_heading_q) - 17'(hd_q)));
	end

	// Restoring division trial for both lanes.
	assign trial_x = {rem_x_q, dvd_x_q[38]};
	assign trial_y = {rem_y_q, dvd_y_q[38]};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= '0;
			goal_dist_q  <= '0;
			goal_dir_q   <= '0;
			duration_q   <= DURATION_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN:      prop_gain_q  <= cfg_data[15:0];
				REG_INTEG_GAIN:     integ_gain_q <= cfg_data[15:0];
				REG_GOAL_DISTANCE:  goal_dist_q  <= cfg_data;
				REG_GOAL_DIRECTION: goal_dir_q   <= signed'(cfg_data[14:0]);
				REG_DURATION_TICKS: duration_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Tracker state that survives from tick to tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			start_heading_q <= '0;
			target_x_q      <= '0;
			target_y_q      <= '0;
			elapsed_q       <= '0;
			sum_x_q         <= '0;
			sum_y_q         <= '0;
			sum_h_q         <= '0;
			last_err_q      <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (!started_q) begin
						started_q       <= 1'b1;
						start_heading_q <= in_data.heading_now;
						elapsed_q       <= '0;
					end
				end
				OP_GMUL_Y: target_x_q <= signed'(goal_fix(prod_q, neg_q));
				OP_GSTORE: target_y_q <= signed'(goal_fix(prod_q, neg_q));
				OP_ERR: begin
					sum_x_q    <= signed'(sat_add(sum_x_q, ex));
					sum_y_q    <= signed'(sat_add(sum_y_q, ey));
					sum_h_q    <= signed'(sat_add(sum_h_q, 26'(last_err_q)));
					last_err_q <= herr;
					if (elapsed_q < duration_q) begin
						elapsed_q <= elapsed_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				px_q    <= in_data.position_x;
				py_q    <= in_data.position_y;
				hd_q    <= in_data.heading_now;
				first_q <= !started_q;
			end
			OP_CINIT: begin
				cx_q  <= CORDIC_X0;
				cy_q  <= '0;
				cz_q  <= {dir_f, 8'h00};
				neg_q <= dir_neg;
			end
			OP_CSTEP: begin
				if (!cz_q[23]) begin
					cx_q <= cx_q - (cy_q >>> cmd.idx);
					cy_q <= cy_q + (cx_q >>> cmd.idx);
					cz_q <= cz_q - cordic_atan(cmd.idx);
				end else begin
					cx_q <= cx_q + (cy_q >>> cmd.idx);
					cy_q <= cy_q - (cx_q >>> cmd.idx);
					cz_q <= cz_q + cordic_atan(cmd.idx);
				end
			end
			OP_GMUL_X, OP_GMUL_Y, OP_IMUL_X, OP_PMUL: begin
				prod_q <= 66'(mul_a) * 66'(mul_b);
			end
			OP_IMUL_Y: begin
				dvd_x_q <= prod_q[38:0];
				rem_x_q <= '0;
				prod_q  <= 66'(mul_a) * 66'(mul_b);
			end
			OP_DSTART: begin
				dvd_y_q <= prod_q[38:0];
				rem_y_q <= '0;
			end
			OP_DSTEP: begin
				if (trial_x >= {1'b0, duration_q}) begin
					rem_x_q <= 16'(trial_x - {1'b0, duration_q});
					dvd_x_q <= {dvd_x_q[37:0], 1'b1};
				end else begin
					rem_x_q <= trial_x[15:0];
					dvd_x_q <= {dvd_x_q[37:0], 1'b0};
				end
				if (trial_y >= {1'b0, duration_q}) begin
					rem_y_q <= 16'(trial_y - {1'b0, duration_q});
					dvd_y_q <= {dvd_y_q[37:0], 1'b1};
				end else begin
					rem_y_q <= trial_y[15:0];
					dvd_y_q <= {dvd_y_q[37:0], 1'b0};
				end
			end
			OP_ERR: begin
				err_x_q <= ex;
				err_y_q <= ey;
			end
			OP_ISUM: begin
				acc_q  <= prod_q;
				prod_q <= 66'(mul_a) * 66'(mul_b);
			end
			OP_ROUND: begin
				case (cmd.idx[1:0])
					2'd0:    vx_q <= signed'(drive_sat(67'(acc_q) + 67'(prod_q)));
					2'd1:    vy_q <= signed'(drive_sat(67'(acc_q) + 67'(prod_q)));
					default: vt_q <= signed'(drive_sat(67'(acc_q) + 67'(prod_q)));
				endcase
			end
			OP_OUT: begin
				out_q.velocity_x     <= vx_q;
				out_q.velocity_y     <= vy_q;
				out_q.turn_rate      <= vt_q;
				out_q.clear_odometry <= first_q;
			end
			default: ;
		endcase
	end

endmodule

/* design/trajectory_pi_goal_tracker_core.sv */
// Goal tracker with PI control, one result per control tick.
// The input channel (in_valid, in_ready, in_data) carries one tick: measured x, y
// in Q7.16 meters and heading in 1/64 degree. The output channel (out_valid,
// out_ready, out_data) returns the x and y velocity, the turn rate and the
// clear_odometry flag. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the gains, goal and duration; it is always ready.
// Each tick places the moving target by the 39-step restoring divider and forms
// the PI terms on the one shared multiplier; the first tick after reset also
// builds the goal point by a 16-step CORDIC and two products first.
// The block holds one tick at a time and takes no new tick until the last one
// is finished.
// Reset clears the integrals, the elapsed count and the started flag; the next
// tick latches the start heading and computes the goal.
// A finished result waits in the output register while the next tick is taken;
// if the receiver still stalls at the end of that tick, the sequencer waits.
module trajectory_pi_goal_tracker_core import tpgt_pkg::*; #(
	parameter int ACC_WIDTH = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// Sequencer.
	tpgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	tpgt_dpath #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

/* design/tpgt_checker.sv */
module tpgt_checker import tpgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// After an input transfer the block is busy with that tick.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

	// A result never shows up in the cycle after its input transfer.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind trajectory_pi_goal_tracker_core tpgt_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* dv/trajectory_pi_goal_tracker_core_tb.sv */
`timescale 1ns / 100ps

module trajectory_pi_goal_tracker_core_tb;
	import tpgt_pkg::*;

	localparam int  ACC_W       = 40;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  DRAIN_WAIT  = 120;

	typedef struct {
		in_t  stim;
		bit   known;
		out_t want;
	} tick_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [22:0] cfg_data;

	// Shadow copy of the tracker's registers and state.
	logic [15:0] kp_q, ki_q, dur_q;
	logic [22:0] goal_dist_q;
	logic [14:0] goal_dir_q;
	bit          started_q;
	longint      start_hd, tgt_x, tgt_y, elapsed_q;
	longint      integ_x, integ_y, integ_hd, prev_hd_err;

	out_t      cmd_expected[$];
	tick_row_t tick_table[$];
	int        mismatches;
	int        cycles;
	bit        calm;
	int        stall_left;

	const longint atan_tab[16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	trajectory_pi_goal_tracker_core #(.ACC_WIDTH(ACC_W)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Goal coordinate along one axis, by the same CORDIC rotation as the block.
	function automatic longint goal_component(bit want_sin);
		longint a, x, y, z, nx, ny, r;
		bit     neg;
		a = longint'($signed(goal_dir_q));
		x = 652032874;
		y = 0;
		neg = 1'b0;
		if (a > HALF_TURN) a -= FULL_TURN;
		if (a < -HALF_TURN) a += FULL_TURN;
		if (a > QUARTER_TURN) begin
			a -= 2 * QUARTER_TURN;
			neg = 1'b1;
		end else if (a < -QUARTER_TURN) begin
			a += 2 * QUARTER_TURN;
			neg = 1'b1;
		end
		z = a * 256;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_tab[i];
			end
			x = nx;
			y = ny;
		end
		r = (longint'(goal_dist_q) * (want_sin ? y : x) + (64'sd1 <<< 29)) >>> 30;
		if (neg) r = -r;
		if (r < -8388608) r = -8388608;
		if (r > 8388607) r = 8388607;
		return r;
	endfunction

	// Target position on the straight line from the origin toward the goal.
	function automatic longint ramp_point(longint tgt);
		longint mag;
		if (elapsed_q >= longint'(dur_q)) return tgt;
		mag = (tgt < 0 ? -tgt : tgt) * elapsed_q / longint'(dur_q);
		return tgt < 0 ? -mag : mag;
	endfunction

	// Integral update with saturation at the accumulator width.
	function automatic longint sat_accumulate(longint sum, longint err);
		longint hi, lo;
		hi = (64'sd1 <<< (ACC_W - 1)) - 1;
		lo = -hi - 1;
		if (err > 0 && sum > hi - err) return hi;
		if (err < 0 && sum < lo - err) return lo;
		return sum + err;
	endfunction

	// PI command, rounded from Q.8 and saturated to 32 bits.
	function automatic logic signed [31:0] pi_command(longint err, longint sum);
		longint cap, acc;
		cap = 64'sd1 <<< 46;
		if (sum > cap) sum = cap;
		if (sum < -cap) sum = -cap;
		acc = longint'(kp_q) * err + longint'(ki_q) * sum;
		acc = (acc + 128) >>> 8;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		return acc[31:0];
	endfunction

	// One control tick: updates the shadow state and returns the command.
	function automatic out_t predict_tick(in_t d);
		longint px, py, hd, ex, ey, eh, r;
		out_t   o;
		px = longint'(d.position_x);
		py = longint'(d.position_y);
		hd = longint'(d.heading_now);
		o.clear_odometry = 1'b0;
		if (!started_q) begin
			start_hd = hd;
			tgt_x = goal_component(1'b0);
			tgt_y = goal_component(1'b1);
			elapsed_q = 0;
			started_q = 1'b1;
			o.clear_odometry = 1'b1;
		end
		ex = ramp_point(tgt_x) - px;
		ey = ramp_point(tgt_y) - py;
		integ_x = sat_accumulate(integ_x, ex);
		integ_y = sat_accumulate(integ_y, ey);
		integ_hd = sat_accumulate(integ_hd, prev_hd_err);
		eh = start_hd - hd;
		r = ((eh % FULL_TURN) + FULL_TURN) % FULL_TURN;
		if (r > HALF_TURN) r -= FULL_TURN;
		prev_hd_err = r;
		o.velocity_x = pi_command(ex, integ_x);
		o.velocity_y = pi_command(ey, integ_y);
		o.turn_rate = pi_command(r, integ_hd);
		if (elapsed_q < longint'(dur_q)) elapsed_q = (elapsed_q + 1) & 16'hFFFF;
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Configuration write; the shadow registers follow on the transfer.
	task automatic write_reg(logic [2:0] idx, logic [22:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_PROP_GAIN:      kp_q = val[15:0];
			REG_INTEG_GAIN:     ki_q = val[15:0];
			REG_GOAL_DISTANCE:  goal_dist_q = val;
			REG_GOAL_DIRECTION: goal_dir_q = val[14:0];
			REG_DURATION_TICKS: dur_q = val[15:0];
			default: ;
		endcase
	endtask

	// One tick transfer; the command it causes is queued on acceptance.
	task automatic send_tick(in_t d, bit known, out_t want);
		int   gap;
		out_t o;
		gap = gap_len();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		o = predict_tick(d);
		cmd_expected.push_back(known ? want : o);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (cmd_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic in_t random_tick();
		in_t d;
		int  p;
		p = $urandom_range(0, 9);
		if (p < 6) begin
			// Robot close to the path: small offsets.
			d.position_x = $signed(24'($urandom_range(0, 1 << 18))) - 24'sd131072;
			d.position_y = $signed(24'($urandom_range(0, 1 << 18))) - 24'sd131072;
		end else if (p < 9) begin
			d.position_x = 24'($urandom);
			d.position_y = 24'($urandom);
		end else begin
			d.position_x = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			d.position_y = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
		end
		d.heading_now = 16'($signed($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
		return d;
	endfunction

	function automatic logic [22:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 23'd0;
			1: return 23'd65535;
			2: return 23'($urandom_range(0, 4096));
			default: return 23'($urandom_range(0, 65535));
		endcase
	endfunction

	// Command ready with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) < 3) stall_left <= gap_len();
		end
	end

	// Command checking against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (cmd_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected command %p", out_data);
			end else begin
				out_t e;
				e = cmd_expected.pop_front();
				if (e.velocity_x !== out_data.velocity_x || e.velocity_y !== out_data.velocity_y
						|| e.turn_rate !== out_data.turn_rate
						|| e.clear_odometry !== out_data.clear_odometry) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Command mismatch: expected %p, actual %p", e, out_data);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [22:0] dur_pick;
		in_t         d;
		out_t        none;
		int          n_items;
		none = '0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		kp_q = PROP_GAIN_RST;
		ki_q = '0;
		goal_dist_q = '0;
		goal_dir_q = '0;
		dur_q = DURATION_RST;
		started_q = 1'b0;
		start_hd = 0;
		tgt_x = 0;
		tgt_y = 0;
		elapsed_q = 0;
		integ_x = 0;
		integ_y = 0;
		integ_hd = 0;
		prev_hd_err = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The goal is latched on the first tick only: farthest goal, with a
		// direction past half a turn so that it wraps into the opposite quadrant.
		write_reg(REG_GOAL_DISTANCE, 23'h7FFFFF);
		write_reg(REG_GOAL_DIRECTION, 23'd16000);
		write_reg(REG_DURATION_TICKS, 23'd8);

		// First tick sits at the origin of the ramp: the command is the
		// default gain of ten times the negated position, with no turn.
		tick_table.push_back('{'{24'sd1, -24'sd1, 16'sd100}, 1'b1,
			'{-32'sd10, 32'sd10, 32'sd0, 1'b1}});
		tick_table.push_back('{'{-24'sd8388608, 24'sd8388607, -16'sd23040}, 1'b0, none});
		tick_table.push_back('{'{24'sd8388607, -24'sd8388608, 16'sd23040}, 1'b0, none});
		tick_table.push_back('{'{24'sd0, 24'sd0, 16'sd0}, 1'b0, none});
		// Heading differences at exactly plus and minus half a turn, both wrapped to plus half a turn.
		tick_table.push_back('{'{24'sd0, 24'sd0, -16'sd11420}, 1'b0, none});
		tick_table.push_back('{'{24'sd0, 24'sd0, 16'sd11620}, 1'b0, none});
		tick_table.push_back('{'{24'sd65536, -24'sd65536, 16'sd101}, 1'b0, none});
		tick_table.push_back('{'{-24'sd1, 24'sd1, 16'sd99}, 1'b0, none});
		// Ramp reaches the goal here and stays there.
		tick_table.push_back('{'{24'sd0, 24'sd0, 16'sd100}, 1'b0, none});
		tick_table.push_back('{'{24'sd0, 24'sd0, 16'sd100}, 1'b0, none});
		tick_table.push_back('{'{24'sd1000, 24'sd2000, 16'sd5000}, 1'b0, none});
		foreach (tick_table[i]) send_tick(tick_table[i].stim, tick_table[i].known,
			tick_table[i].want);
		drain();

		// Gain extremes, including outputs that saturate.
		write_reg(REG_PROP_GAIN, 23'd65535);
		write_reg(REG_INTEG_GAIN, 23'd65535);
		send_tick('{24'sh7FFFFF, 24'sh800000, 16'sd23040}, 1'b0, none);
		send_tick('{24'sh800000, 24'sh7FFFFF, -16'sd23040}, 1'b0, none);
		drain();
		write_reg(REG_PROP_GAIN, 23'd0);
		write_reg(REG_INTEG_GAIN, 23'd0);
		// Indexes past the last register are ignored.
		write_reg(3'd5, 23'h7FFFFF);
		write_reg(3'd7, 23'h555555);
		send_tick('{24'sd12345, -24'sd54321, 16'sd777}, 1'b0, none);
		drain();

		// Random phases, each under a new setting.
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 4 == 3);
			write_reg(REG_PROP_GAIN, pick_gain());
			write_reg(REG_INTEG_GAIN, pick_gain());
			// Goal writes after the first tick must change nothing.
			write_reg(REG_GOAL_DISTANCE, 23'($urandom));
			write_reg(REG_GOAL_DIRECTION, 23'($urandom));
			case (ph % 5)
				0: dur_pick = 23'd0;
				1: dur_pick = 23'd65535;
				2: dur_pick = 23'd1;
				3: dur_pick = 23'($urandom_range(2, 40));
				default: dur_pick = 23'($urandom_range(0, 65535));
			endcase
			write_reg(REG_DURATION_TICKS, dur_pick);
			if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), 23'($urandom));
			n_items = $urandom_range(65, 80);
			for (int k = 0; k < n_items; k++) begin
				d = random_tick();
				send_tick(d, 1'b0, none);
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && cmd_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
